FILE: rtl/lgti_pkg.sv
package lgti_pkg;

  localparam int LUX_W  = 32;
  localparam int LOG_W  = 16;
  localparam int POW_W  = 20;
  localparam int DVD_W  = 29;
  localparam int QUO_W  = 9;
  localparam int ROM_W  = 14;
  localparam int DIFF_W = 9;
  localparam int ROM_N  = 91;
  localparam int IDX_W  = 7;
  localparam int DEC_W  = 3;
  localparam int CNT_W  = 4;
  localparam int DEC_MAX = 6;

  localparam logic [LUX_W-1:0] SAT_LIMIT      = 32'd3576000;
  localparam logic [LOG_W-1:0] SAT_VALUE      = 16'd65534;
  localparam logic [LOG_W-1:0] DECADE_WEIGHT  = 16'd10000;
  localparam logic [QUO_W-1:0] MANT_MIN       = 9'd10;
  localparam logic [QUO_W-1:0] MANT_MAX       = 9'd99;
  localparam logic [CNT_W-1:0] DIV_LAST       = CNT_W'(QUO_W - 1);

  localparam logic [POW_W-1:0] POW10 [DEC_MAX+1] = '{
    20'd1, 20'd10, 20'd100, 20'd1000, 20'd10000, 20'd100000, 20'd1000000
  };

  localparam logic [ROM_W-1:0] LOG_ROM [ROM_N] = '{
        0,  414,  792, 1139, 1461, 1761, 2041, 2304, 2553, 2788,
     3010, 3222, 3424, 3617, 3802, 3979, 4150, 4314, 4472, 4624,
     4771, 4914, 5052, 5185, 5315, 5441, 5563, 5682, 5798, 5911,
     6021, 6128, 6232, 6335, 6435, 6532, 6628, 6721, 6812, 6902,
     6990, 7076, 7160, 7243, 7324, 7404, 7482, 7559, 7634, 7709,
     7782, 7853, 7924, 7993, 8062, 8129, 8195, 8261, 8325, 8388,
     8451, 8513, 8573, 8633, 8692, 8751, 8808, 8865, 8921, 8976,
     9031, 9085, 9138, 9191, 9243, 9294, 9345, 9395, 9445, 9494,
     9542, 9590, 9638, 9685, 9731, 9777, 9823, 9868, 9912, 9956,
    10000
  };

  typedef struct packed {
    logic load;
    logic div_step;
    logic lut;
    logic mul;
    logic fin;
  } ctl_cmd_t;

  typedef struct packed {
    logic special;
  } ctl_sts_t;

  function automatic logic [DEC_W-1:0] decade_of(input logic [LUX_W-1:0] x);
    logic [DEC_W-1:0] d;
    d = '0;
    for (int k = 1; k <= DEC_MAX; k++) begin
      if (x >= LUX_W'(POW10[k])) begin
        d = d + 1'b1;
      end
    end
    return d;
  endfunction

endpackage

FILE: rtl/log10_x10000_table_interp_top.sv
// Fixed-point base-ten logarithm: out_log_scaled approximates 10000 * log10(in_lux_value) by table interpolation.
// A transfer in happens at a rising edge where start is high and busy is low;
// in_lux_value is sampled at that edge and busy stays high until the result is out.
// The result appears on out_log_scaled for exactly one cycle with out_valid high,
// and the receiver takes it at the edge that ends that cycle; it cannot stall.
// A zero input gives 0, and inputs of 3576000 or more give 65534.
// For ordinary inputs the work from the accepting edge to the out_valid cycle runs:
// one restoring divide of nine compare-subtract steps forms the two-digit
// mantissa, a table lookup and one multiply form the interpolation numerator,
// and the same divide unit runs nine more steps to round the interpolation.
// Zero and saturated inputs skip the divides, lookup and multiply and go straight to the result.
// One item is in flight at a time; busy falls in the out_valid cycle, so a new
// item can be accepted while the previous result is being presented.
// A synchronous reset on rst_n returns the controller to idle and clears
// out_valid; a result in progress is dropped.
module log10_x10000_table_interp_top (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  logic [lgti_pkg::LUX_W-1:0]  in_lux_value,
  output logic                        out_valid,
  output logic [lgti_pkg::LOG_W-1:0]  out_log_scaled
);
  import lgti_pkg::*;

  ctl_cmd_t cmd;
  ctl_sts_t sts;

  lgti_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .sts   (sts),
    .cmd   (cmd)
  );

  lgti_dp u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .sts            (sts),
    .in_lux_value   (in_lux_value),
    .out_valid      (out_valid),
    .out_log_scaled (out_log_scaled)
  );

  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("out_valid held for more than one cycle");

  a_result_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy) && !busy)
    else $error("result presented without a finished computation");

  a_accept_goes_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("accepted item did not start the controller");

  a_result_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_log_scaled <= SAT_VALUE)
    else $error("result above the saturation value");

endmodule

FILE: rtl/lgti_ctrl.sv
module lgti_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  lgti_pkg::ctl_sts_t sts,
  output lgti_pkg::ctl_cmd_t cmd
);
  import lgti_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_DIV1 = 3'd1;
  localparam logic [2:0] S_LUT  = 3'd2;
  localparam logic [2:0] S_MUL  = 3'd3;
  localparam logic [2:0] S_DIV2 = 3'd4;
  localparam logic [2:0] S_FIN  = 3'd5;

  logic [2:0]       state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  assign busy = (state_r != S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          cnt_nxt   = '0;
          state_nxt = S_DIV1;
        end
      end
      S_DIV1: begin
        if (sts.special) begin
          state_nxt = S_FIN;
        end else begin
          cmd.div_step = 1'b1;
          if (cnt_r == DIV_LAST) begin
            state_nxt = S_LUT;
          end else begin
            cnt_nxt = cnt_r + 1'b1;
          end
        end
      end
      S_LUT: begin
        cmd.lut   = 1'b1;
        state_nxt = S_MUL;
      end
      S_MUL: begin
        cmd.mul   = 1'b1;
        cnt_nxt   = '0;
        state_nxt = S_DIV2;
      end
      S_DIV2: begin
        cmd.div_step = 1'b1;
        if (cnt_r == DIV_LAST) begin
          state_nxt = S_FIN;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      S_FIN: begin
        cmd.fin   = 1'b1;
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

endmodule

FILE: rtl/lgti_dp.sv
module lgti_dp (
  input  logic                        clk,
  input  logic                        rst_n,
  input  lgti_pkg::ctl_cmd_t          cmd,
  output lgti_pkg::ctl_sts_t          sts,
  input  logic [lgti_pkg::LUX_W-1:0]  in_lux_value,
  output logic                        out_valid,
  output logic [lgti_pkg::LOG_W-1:0]  out_log_scaled
);
  import lgti_pkg::*;

  logic [DEC_W-1:0]  dec_r;
  logic [POW_W-1:0]  p_r;
  logic              zero_r, sat_r;
  logic [DVD_W-1:0]  rem_r, rem_nxt;
  logic [DVD_W-1:0]  dvs_r, dvs_nxt;
  logic [QUO_W-1:0]  q_r, q_nxt;
  logic [ROM_W-1:0]  base_r;
  logic [DIFF_W-1:0] diff_r;
  logic [POW_W-1:0]  r_r;
  logic              valid_r;
  logic [LOG_W-1:0]  res_r;

  logic [DEC_W-1:0]  dec_in;
  logic [POW_W-1:0]  p_in;
  logic [LUX_W-1:0]  t_in;
  logic [QUO_W-1:0]  mant;
  logic [IDX_W-1:0]  idx;
  logic [ROM_W-1:0]  rom_lo, rom_hi;
  logic [DVD_W-1:0]  prod, num;
  logic [LOG_W-1:0]  sum;

  assign sts.special = zero_r | sat_r;

  assign dec_in = decade_of(in_lux_value);
  assign p_in   = POW10[dec_in];
  assign t_in   = (in_lux_value << 3) + (in_lux_value << 1);

  always_comb begin
    rem_nxt = rem_r;
    q_nxt   = {q_r[QUO_W-2:0], 1'b0};
    if (rem_r >= dvs_r) begin
      rem_nxt = rem_r - dvs_r;
      q_nxt   = {q_r[QUO_W-2:0], 1'b1};
    end
    dvs_nxt = dvs_r >> 1;
  end

  always_comb begin
    mant = q_r;
    if (mant < MANT_MIN) begin
      mant = MANT_MIN;
    end
    if (mant > MANT_MAX) begin
      mant = MANT_MAX;
    end
    idx    = IDX_W'(mant - MANT_MIN);
    rom_lo = LOG_ROM[idx];
    rom_hi = LOG_ROM[IDX_W'(idx + 1'b1)];
  end

  assign prod = diff_r * r_r;
  assign num  = prod + DVD_W'(p_r >> 1);
  assign sum  = LOG_W'(dec_r) * DECADE_WEIGHT + LOG_W'(base_r) + LOG_W'(q_r);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      dec_r  <= dec_in;
      p_r    <= p_in;
      zero_r <= (in_lux_value == '0);
      sat_r  <= (in_lux_value >= SAT_LIMIT);
      rem_r  <= t_in[DVD_W-1:0];
      dvs_r  <= DVD_W'(p_in) << (QUO_W - 1);
      q_r    <= '0;
    end else if (cmd.div_step) begin
      rem_r <= rem_nxt;
      dvs_r <= dvs_nxt;
      q_r   <= q_nxt;
    end else if (cmd.lut) begin
      base_r <= rom_lo;
      diff_r <= DIFF_W'(rom_hi - rom_lo);
      r_r    <= rem_r[POW_W-1:0];
    end else if (cmd.mul) begin
      rem_r <= num;
      dvs_r <= DVD_W'(p_r) << (QUO_W - 1);
      q_r   <= '0;
    end
    if (cmd.fin) begin
      if (zero_r) begin
        res_r <= '0;
      end else if (sat_r) begin
        res_r <= SAT_VALUE;
      end else begin
        res_r <= sum;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= cmd.fin;
    end
  end

  assign out_valid      = valid_r;
  assign out_log_scaled = res_r;

endmodule

FILE: dv/tb_top.sv
module tb_top;
  import lgti_pkg::*;

  localparam int unsigned LUX_CEILING    = 3576000;
  localparam int unsigned LOG_SATURATED  = 65534;
  localparam int unsigned LOG_PER_DECADE = 10000;
  localparam int unsigned TOP_DECADE     = 6;
  localparam int          RANDOM_ITEMS   = 1125;
  localparam int          CALM_TAIL      = 120;
  localparam int          SETTLE_CYCLES  = 40;
  localparam int          WATCHDOG_LIMIT = 2000;

  localparam int unsigned DECADE_POW [8] = '{
    1, 10, 100, 1000, 10000, 100000, 1000000, 10000000
  };

  // 10000 * log10(i / 10) for i = 10 .. 100.
  localparam int unsigned TENTHS_LOG [91] = '{
        0,  414,  792, 1139, 1461, 1761, 2041, 2304, 2553, 2788,
     3010, 3222, 3424, 3617, 3802, 3979, 4150, 4314, 4472, 4624,
     4771, 4914, 5052, 5185, 5315, 5441, 5563, 5682, 5798, 5911,
     6021, 6128, 6232, 6335, 6435, 6532, 6628, 6721, 6812, 6902,
     6990, 7076, 7160, 7243, 7324, 7404, 7482, 7559, 7634, 7709,
     7782, 7853, 7924, 7993, 8062, 8129, 8195, 8261, 8325, 8388,
     8451, 8513, 8573, 8633, 8692, 8751, 8808, 8865, 8921, 8976,
     9031, 9085, 9138, 9191, 9243, 9294, 9345, 9395, 9445, 9494,
     9542, 9590, 9638, 9685, 9731, 9777, 9823, 9868, 9912, 9956,
    10000
  };

  typedef logic [LUX_W-1:0] lux_t;
  typedef logic [LOG_W-1:0] log_t;

  typedef struct {
    lux_t lux;
    log_t log_val;
  } pending_log_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  lux_t in_lux_value = '0;
  logic busy;
  logic out_valid;
  log_t out_log_scaled;

  lux_t         lux_queue [$];
  pending_log_t pending_logs [$];

  int unsigned fail_count = 0;
  int unsigned results_seen = 0;
  int unsigned zero_seen = 0;
  int unsigned saturated_seen = 0;
  int unsigned quiet_cycles = 0;
  int          gap_left = 0;
  bit          burst_mode = 1'b1;

  log10_x10000_table_interp_top DUT (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_lux_value   (in_lux_value),
    .out_valid      (out_valid),
    .out_log_scaled (out_log_scaled)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic log_t lux_to_log(input lux_t x);
    int unsigned dec;
    int unsigned scale;
    int unsigned mant;
    int unsigned rem;
    int unsigned slope;
    int unsigned interp;
    longint unsigned scaled_x;
    if (x == '0) begin
      return '0;
    end
    if (x >= LUX_CEILING) begin
      return log_t'(LOG_SATURATED);
    end
    dec = 0;
    scale = 1;
    while (dec < TOP_DECADE && DECADE_POW[dec + 1] <= x) begin
      dec++;
      scale = DECADE_POW[dec];
    end
    scaled_x = longint'(x) * 10;
    mant = int'(scaled_x / scale);
    rem = int'(scaled_x % scale);
    if (mant < 10) begin
      mant = 10;
    end
    if (mant > 99) begin
      mant = 99;
    end
    slope = TENTHS_LOG[mant - 9] - TENTHS_LOG[mant - 10];
    interp = (slope * rem + scale / 2) / scale;
    return log_t'(dec * LOG_PER_DECADE + TENTHS_LOG[mant - 10] + interp);
  endfunction

  function automatic lux_t random_lux();
    int unsigned kind;
    int unsigned dec;
    int unsigned hi;
    int unsigned base;
    kind = $urandom_range(99, 0);
    if (kind < 65) begin
      dec = $urandom_range(TOP_DECADE, 0);
      hi = (dec == TOP_DECADE) ? LUX_CEILING - 1 : DECADE_POW[dec + 1] - 1;
      return lux_t'($urandom_range(hi, DECADE_POW[dec]));
    end else if (kind < 78) begin
      dec = $urandom_range(TOP_DECADE + 1, 1);
      base = (dec > TOP_DECADE) ? LUX_CEILING : DECADE_POW[dec];
      return lux_t'(base + $urandom_range(4, 0) - 2);
    end else if (kind < 92) begin
      return lux_t'($urandom());
    end else if (kind < 96) begin
      return lux_t'($urandom_range(20, 0));
    end
    return lux_t'(LUX_CEILING + $urandom_range(1000, 0));
  endfunction

  always @(posedge clk) begin : drive
    logic next_start;
    lux_t next_lux;
    bit   may_idle;
    if (!rst_n) begin
      start <= 1'b0;
      in_lux_value <= '0;
      gap_left = 0;
    end else begin
      next_start = start;
      next_lux = in_lux_value;
      may_idle = burst_mode && (lux_queue.size() > CALM_TAIL);
      if ($urandom_range(199, 0) == 0) begin
        burst_mode = !burst_mode;
      end
      if (start && !busy) begin
        pending_logs.push_back('{lux: in_lux_value, log_val: lux_to_log(in_lux_value)});
        void'(lux_queue.pop_front());
        if (may_idle && $urandom_range(3, 0) == 0) begin
          gap_left = $urandom_range(6, 1);
        end
      end else if (gap_left == 0 && may_idle && $urandom_range(15, 0) == 0) begin
        gap_left = $urandom_range(6, 1);
      end
      if (gap_left > 0) begin
        gap_left--;
        next_start = 1'b0;
      end else if (lux_queue.size() > 0) begin
        next_start = 1'b1;
        next_lux = lux_queue[0];
      end else begin
        next_start = 1'b0;
      end
      start <= next_start;
      in_lux_value <= next_lux;
    end
  end

  always @(posedge clk) begin : watch
    pending_log_t want;
    if (rst_n) begin
      if ((start && !busy) || out_valid) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: no transfer for %0d cycles", $time, quiet_cycles);
        $display("FAILED: results differ");
        $finish;
      end else if (out_valid) begin
        results_seen++;
        if (pending_logs.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual %0d",
                   $time, out_log_scaled);
          fail_count++;
        end else begin
          want = pending_logs.pop_front();
          if (want.lux == '0) begin
            zero_seen++;
          end
          if (want.lux >= LUX_CEILING) begin
            saturated_seen++;
          end
          if (out_log_scaled !== want.log_val) begin
            $display("%0t: lux %0d log_scaled expected %0d actual %0d",
                     $time, want.lux, want.log_val, out_log_scaled);
            fail_count++;
          end
        end
      end
    end
  end

  initial begin
    lux_t directed [$];
    directed = '{
      32'd0, 32'd1, 32'd5, 32'd9, 32'd10, 32'd11, 32'd15, 32'd99, 32'd100,
      32'd999, 32'd1000, 32'd9999, 32'd10000, 32'd12345, 32'd99999,
      32'd100000, 32'd999999, 32'd1000000, 32'd1234567, 32'd2999999,
      32'd3575999, 32'd3576000, 32'd3576001, 32'h8000_0000, 32'hFFFF_FFFF
    };
    foreach (directed[i]) begin
      lux_queue.push_back(directed[i]);
    end
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      lux_queue.push_back(random_lux());
    end
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    while (lux_queue.size() > 0 || pending_logs.size() > 0) begin
      @(posedge clk);
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("Checked %0d results, %0d of them for zero input and %0d saturated.",
             results_seen, zero_seen, saturated_seen);
    $display("Inputs spanned every decade, its boundaries and random 32-bit values.");
    if (fail_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

FILE: log10_x10000_table_interp_top.f
rtl/lgti_pkg.sv
rtl/lgti_ctrl.sv
rtl/lgti_dp.sv
rtl/log10_x10000_table_interp_top.sv
dv/tb_top.sv
